### rtl/rrac_pkg.sv
// Package for the range rule avoidance command block: field widths, register
// indexes, reset values, mode codes and the sideband carried down the pipeline.
// No dependencies.
package rrac_pkg;

  localparam int DIST_W  = 16;  // distances, speeds, gain
  localparam int LIMIT_W = 15;  // turn rate limit
  localparam int RATE_W  = 16;  // signed turn rate
  localparam int SUM_W   = DIST_W + 1;          // left + right
  localparam int PROD_W  = 2 * DIST_W;          // gain * |left - right|
  localparam int SCALE_W = 10;                  // width of the mrad scale
  localparam int WIDE_W  = PROD_W + SCALE_W;    // gain * |l - r| * 1000
  localparam int FRAC_W  = 12;                  // Q4.12 fraction bits
  localparam int DIVD_W  = WIDE_W - FRAC_W;     // dividend after dropping fraction
  localparam int QUO_W   = 14;                  // quotient stays below 16000
  localparam int CFG_IDX_W = 3;

  localparam logic [SCALE_W-1:0] STEER_SCALE = SCALE_W'(1000);

  localparam logic [DIST_W-1:0]  RST_STOP   = DIST_W'(500);
  localparam logic [DIST_W-1:0]  RST_AVOID  = DIST_W'(900);
  localparam logic [DIST_W-1:0]  RST_SIDE   = DIST_W'(600);
  localparam logic [DIST_W-1:0]  RST_CRUISE = DIST_W'(200);
  localparam logic [DIST_W-1:0]  RST_CREEP  = DIST_W'(80);
  localparam logic [LIMIT_W-1:0] RST_LIMIT  = LIMIT_W'(600);
  localparam logic [DIST_W-1:0]  RST_GAIN   = DIST_W'(3277);

  typedef enum logic [2:0] {
    MODE_NO_SCAN       = 3'd0,
    MODE_FRONT_UNKNOWN = 3'd1,
    MODE_BLOCKED       = 3'd2,
    MODE_AVOID         = 3'd3,
    MODE_FORWARD       = 3'd4,
    MODE_STEER         = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP   = 3'd0,
    CFG_AVOID  = 3'd1,
    CFG_SIDE   = 3'd2,
    CFG_CRUISE = 3'd3,
    CFG_CREEP  = 3'd4,
    CFG_LIMIT  = 3'd5,
    CFG_GAIN   = 3'd6
  } cfg_idx_t;

  // Per-item decision that rides alongside the steering division.
  typedef struct packed {
    logic [DIST_W-1:0]        speed;
    logic signed [RATE_W-1:0] rate;   // fixed turn for the turning rules
    mode_t                    mode;
    logic                     steer;  // take the rate from the division
    logic                     neg;    // right side clearer: negate steering
  } side_t;

endpackage

### rtl/range_rule_avoidance_command_top.sv
// Top level of the range rule avoidance command block: rule decision,
// steering product and output register. Depends on rrac_pkg and rrac_steer_div.
//
//   channel  | handshake              | beat
//   ---------+------------------------+-----------------------------------------
//   input    | start high, busy low   | front, left, right, nearest, point count
//   result   | out_valid strobe       | linear speed, angular rate, mode code
//   config   | cfg_we                 | cfg_index, cfg_wdata (16 bit)
//
// Every item passes 18 register stages: one decision stage, two multiply
// stages, fourteen divider stages (one quotient bit each) and the output
// register. A new beat enters every cycle, so busy stays low. Synchronous
// active-low reset clears the valid bits and loads the register reset
// values. The receiver cannot stall, so nothing ever holds: every beat
// drains out in order.
module range_rule_avoidance_command_top
  import rrac_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [DIST_W-1:0]        in_front_mm,
  input  logic [DIST_W-1:0]        in_left_mm,
  input  logic [DIST_W-1:0]        in_right_mm,
  input  logic [DIST_W-1:0]        in_nearest_mm,
  input  logic [DIST_W-1:0]        in_point_count,
  output logic                     out_valid,
  output logic [DIST_W-1:0]        out_linear_speed,
  output logic signed [RATE_W-1:0] out_angular_rate,
  output logic [2:0]               out_mode_code,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIST_W-1:0]        cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]  stop_r, avoid_r, side_safe_r, cruise_r, creep_r, gain_r;
  logic [LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r      <= RST_STOP;
      avoid_r     <= RST_AVOID;
      side_safe_r <= RST_SIDE;
      cruise_r    <= RST_CRUISE;
      creep_r     <= RST_CREEP;
      limit_r     <= RST_LIMIT;
      gain_r      <= RST_GAIN;
    end else if (cfg_we) begin
      // Drop writes to the unused index.
      unique case (cfg_idx_t'(cfg_index))
        CFG_STOP:   stop_r      <= cfg_wdata;
        CFG_AVOID:  avoid_r     <= cfg_wdata;
        CFG_SIDE:   side_safe_r <= cfg_wdata;
        CFG_CRUISE: cruise_r    <= cfg_wdata;
        CFG_CREEP:  creep_r     <= cfg_wdata;
        CFG_LIMIT:  limit_r     <= cfg_wdata[LIMIT_W-1:0];
        CFG_GAIN:   gain_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Every cycle takes a beat.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: pick the rule, form |left - right| and left + right
  // ---------------------------------------------------------------------------
  logic                     lv, rv, turn_left;
  logic signed [RATE_W-1:0] turn;
  side_t                    s1_side_nxt, s1_side_r;
  logic [DIST_W-1:0]        s1_mag_nxt, s1_mag_r;
  logic [SUM_W-1:0]         s1_sum_nxt, s1_sum_r;
  logic                     s1_vld_r;

  always_comb begin
    lv        = in_left_mm != '0;
    rv        = in_right_mm != '0;
    // Favor the clearer side; fall back to left when neither side is known.
    turn_left = (lv && rv) ? (in_left_mm >= in_right_mm) : (lv || !rv);
    turn      = turn_left ? $signed({1'b0, limit_r}) : -$signed({1'b0, limit_r});

    s1_side_nxt.speed = '0;
    s1_side_nxt.rate  = '0;
    s1_side_nxt.mode  = MODE_NO_SCAN;
    s1_side_nxt.steer = 1'b0;
    s1_side_nxt.neg   = in_left_mm < in_right_mm;

    priority if (in_point_count == '0 || in_nearest_mm == '0) begin
      s1_side_nxt.mode = MODE_NO_SCAN;
    end else if (in_front_mm == '0) begin
      s1_side_nxt.mode = MODE_FRONT_UNKNOWN;
    end else if (in_front_mm < stop_r) begin
      s1_side_nxt.rate = turn;
      s1_side_nxt.mode = MODE_BLOCKED;
    end else if (in_front_mm < avoid_r) begin
      s1_side_nxt.speed = creep_r;
      s1_side_nxt.rate  = turn;
      s1_side_nxt.mode  = MODE_AVOID;
    end else begin
      s1_side_nxt.speed = cruise_r;
      s1_side_nxt.steer = lv && rv;   // one side blind: no steering
      if ((lv && in_left_mm < side_safe_r) || (rv && in_right_mm < side_safe_r)) begin
        s1_side_nxt.mode = MODE_STEER;
      end else begin
        s1_side_nxt.mode = MODE_FORWARD;
      end
    end

    if (in_left_mm < in_right_mm) begin
      s1_mag_nxt = in_right_mm - in_left_mm;
    end else begin
      s1_mag_nxt = in_left_mm - in_right_mm;
    end
    s1_sum_nxt = SUM_W'(in_left_mm) + SUM_W'(in_right_mm);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gain * |l - r|.  Stage 3: times 1000, drop the Q4.12 fraction.
  // Flooring early is exact: floor(floor(a / 4096) / s) = floor(a / (4096 s)).
  // ---------------------------------------------------------------------------
  side_t             s2_side_r, s3_side_r;
  logic [PROD_W-1:0] s2_prod_r;
  logic [SUM_W-1:0]  s2_sum_r, s3_sum_r;
  logic [WIDE_W-1:0] s3_wide;
  logic [DIVD_W-1:0] s3_x_r;
  logic              s2_vld_r, s3_vld_r;

  assign s3_wide = WIDE_W'(s2_prod_r) * WIDE_W'(STEER_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r <= s1_side_nxt;
    s1_mag_r  <= s1_mag_nxt;
    s1_sum_r  <= s1_sum_nxt;
    s2_side_r <= s1_side_r;
    s2_prod_r <= PROD_W'(gain_r) * PROD_W'(s1_mag_r);
    s2_sum_r  <= s1_sum_r;
    s3_side_r <= s2_side_r;
    s3_x_r    <= s3_wide[WIDE_W-1:FRAC_W];
    s3_sum_r  <= s2_sum_r;
  end

  // ---------------------------------------------------------------------------
  // Divider: quotient of the scaled product by left + right
  // ---------------------------------------------------------------------------
  logic             dv_vld;
  logic [QUO_W-1:0] dv_q;
  side_t            dv_side;

  rrac_steer_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_x      (s3_x_r),
    .in_s      (s3_sum_r),
    .in_side   (s3_side_r),
    .out_valid (dv_vld),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // ---------------------------------------------------------------------------
  // Output stage: clamp and sign the steering, pick the rate, register
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0]       q_clamp;
  logic signed [RATE_W-1:0] rate_nxt;
  logic                     out_vld_r;
  logic [DIST_W-1:0]        out_speed_r;
  logic signed [RATE_W-1:0] out_rate_r;
  mode_t                    out_mode_r;

  always_comb begin
    if (LIMIT_W'(dv_q) > limit_r) begin
      q_clamp = limit_r;
    end else begin
      q_clamp = LIMIT_W'(dv_q);
    end
    if (dv_side.steer) begin
      rate_nxt = dv_side.neg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
    end else begin
      rate_nxt = dv_side.rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_speed_r <= dv_side.speed;
    out_rate_r  <= rate_nxt;
    out_mode_r  <= dv_side.mode;
  end

  assign out_valid        = out_vld_r;
  assign out_linear_speed = out_speed_r;
  assign out_angular_rate = out_rate_r;
  assign out_mode_code    = out_mode_r;

endmodule

### rtl/rrac_steer_div.sv
// Pipelined restoring divider for the steering term, one quotient bit per stage.
// Depends on rrac_pkg for widths and the sideband struct.
module rrac_steer_div
  import rrac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [DIVD_W-1:0] in_x,
  input  logic [SUM_W-1:0]  in_s,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_q,
  output side_t             out_side
);

  logic [QUO_W-1:0] vld_r;
  logic [SUM_W-1:0] rem_r  [QUO_W];
  logic [SUM_W-1:0] rem_nxt[QUO_W];
  logic [QUO_W-1:0] xs_r   [QUO_W];
  logic [QUO_W-1:0] quo_r  [QUO_W];
  logic [SUM_W-1:0] sdiv_r [QUO_W];
  side_t            side_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             vld_in;
    logic [SUM_W-1:0] rem_in;
    logic [QUO_W-1:0] xs_in;
    logic [QUO_W-1:0] quo_in;
    logic [SUM_W-1:0] sdiv_in;
    side_t            side_in;
    logic [SUM_W:0]   trial;
    logic             fits;

    if (k == 0) begin : g_first
      // Upper dividend bits are already below the divisor.
      assign vld_in  = in_valid;
      assign rem_in  = {1'b0, in_x[DIVD_W-1:QUO_W]};
      assign xs_in   = in_x[QUO_W-1:0];
      assign quo_in  = '0;
      assign sdiv_in = in_s;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign xs_in   = xs_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign sdiv_in = sdiv_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = {rem_in, xs_in[QUO_W-1]};
    assign fits  = trial >= {1'b0, sdiv_in};

    always_comb begin
      if (fits) begin
        rem_nxt[k] = SUM_W'(trial - {1'b0, sdiv_in});
      end else begin
        rem_nxt[k] = trial[SUM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt[k];
      xs_r[k]   <= {xs_in[QUO_W-2:0], 1'b0};
      quo_r[k]  <= {quo_in[QUO_W-2:0], fits};
      sdiv_r[k] <= sdiv_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_q     = quo_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

endmodule
